/* hdl/rsfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfd_pkg
// shared constants and types of the rc serial frame decoder
// ----------------------------------------------------------------------------
package rsfd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CHANNEL_BITS = 11;
  localparam int STORE_BITS   = NUM_CHANNELS * CHANNEL_BITS;
  localparam int DATA_BYTES   = STORE_BITS / 8;
  localparam int POS_W        = 5;
  localparam int IDX_W        = 4;

  localparam logic [POS_W-1:0] HUNT_POS  = POS_W'(0);
  localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);
  localparam logic [POS_W-1:0] LAST_DATA = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0] FLAG_POS  = POS_W'(DATA_BYTES + 1);
  localparam logic [POS_W-1:0] END_POS   = POS_W'(DATA_BYTES + 2);

  localparam logic [7:0] START_CODE = 8'h0F;
  localparam logic [7:0] END_CODE   = 8'h00;

  localparam int FAILSAFE_BIT = 3;
  localparam int LOST_BIT     = 2;

  // status handed from the unpacker to the burst emitter
  typedef struct packed {
    logic done;
    logic failsafe;
    logic lost;
  } frame_stat_t;

endpackage

/* hdl/rsfd_unpacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfd_unpacker
// frame position tracking, bit stream assembly and flag capture
// ----------------------------------------------------------------------------
module rsfd_unpacker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  input  logic                           emit_busy,
  output logic [rsfd_pkg::STORE_BITS-1:0] store,
  output rsfd_pkg::frame_stat_t          stat
);
  import rsfd_pkg::*;

  logic [POS_W-1:0] pos;
  logic             accept;

  // hold the end byte while the previous burst is still draining
  assign in_ready = !((pos == END_POS) && emit_busy);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= HUNT_POS;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (accept) begin
        if ((pos >= FIRST_POS) && (pos <= LAST_DATA)) begin
          // lsb-first stream: after all data bytes, byte one sits at the bottom
          store <= {rx_byte, store[STORE_BITS-1:8]};
          pos   <= pos + POS_W'(1);
        end else if (pos == FLAG_POS) begin
          stat.failsafe <= rx_byte[FAILSAFE_BIT];
          stat.lost     <= rx_byte[LOST_BIT];
          pos           <= END_POS;
        end else if (pos == END_POS) begin
          pos       <= HUNT_POS;
          stat.done <= (rx_byte == END_CODE);
        end else begin
          pos <= (rx_byte == START_CODE) ? FIRST_POS : HUNT_POS;
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= END_POS) else $error("frame position beyond end byte");

  a_done_from_end: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> ($past(pos) == END_POS)) else $error("frame done not from end byte");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (pos == END_POS)) else $error("stall outside end byte");

endmodule

/* hdl/rsfd_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfd_emitter
// snapshots a finished frame and sends its channels one per request
// ----------------------------------------------------------------------------
module rsfd_emitter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rsfd_pkg::STORE_BITS-1:0] store,
  input  rsfd_pkg::frame_stat_t           stat,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsfd_pkg::IDX_W-1:0]      channel_index,
  output logic [rsfd_pkg::CHANNEL_BITS-1:0] channel_value,
  output logic                            failsafe,
  output logic                            link_lost,
  output logic                            last_channel
);
  import rsfd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  logic [STORE_BITS-1:0] snap;
  logic [IDX_W-1:0]      idx;
  logic                  fs_held;
  logic                  lost_held;
  logic                  out_accept;

  assign out_accept = busy && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (stat.done) begin
      busy      <= 1'b1;
      idx       <= '0;
      snap      <= store;
      fs_held   <= stat.failsafe;
      lost_held <= stat.lost;
    end else if (out_accept) begin
      snap <= {{CHANNEL_BITS{1'b0}}, snap[STORE_BITS-1:CHANNEL_BITS]};
      idx  <= idx + IDX_W'(1);
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

  assign out_valid     = busy;
  assign channel_index = idx;
  assign channel_value = snap[CHANNEL_BITS-1:0];
  assign failsafe      = fs_held;
  assign link_lost     = lost_held;
  assign last_channel  = (idx == LAST_IDX);

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !busy) else $error("frame finished while burst still active");

  a_start_idx: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> (busy && (idx == '0))) else $error("burst did not start at channel zero");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (idx == '0)) else $error("channel index not cleared when idle");

  a_end_burst: assert property (@(posedge clk) disable iff (rst)
    (out_accept && last_channel) |=> !busy) else $error("burst ran past last channel");

endmodule

/* hdl/rc_serial_frame_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_core
// byte-serial decoder for 16-channel s.bus style frames
// ----------------------------------------------------------------------------
// The block takes one received byte per request on the slave side and may
// take a byte every cycle. It hunts for start byte 0x0F, shifts the next 22
// bytes lsb-first into a 176-bit channel store, captures failsafe (bit 3)
// and frame-lost (bit 2) from the flag byte, and on an end byte of 0x00
// copies the store into an output snapshot. The snapshot sends the 16
// channels on the master side, one per request and at most one per cycle,
// with tlast on channel 15; a frame with a bad end byte gives no output.
// Bytes of the next frame are taken while a burst drains; only the next end
// byte waits until the previous burst has gone out, so a frame of 25 bytes
// goes in without a stall as long as the output side keeps up with one result
// per cycle. No clearing pass after reset is needed.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                 // [15] failsafe, [16] link_lost, [23:17] zero
  output logic        m_tlast    // last_channel
);
  import rsfd_pkg::*;

  logic [STORE_BITS-1:0]   store;
  frame_stat_t             stat;
  logic                    emit_busy;
  logic [IDX_W-1:0]        channel_index;
  logic [CHANNEL_BITS-1:0] channel_value;
  logic                    failsafe;
  logic                    link_lost;

  // position tracking and stream assembly, one byte per request
  rsfd_unpacker u_unpacker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .rx_byte   (s_tdata),
    .emit_busy (emit_busy),
    .store     (store),
    .stat      (stat)
  );

  // snapshot of a good frame, drained one channel per request
  rsfd_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .store         (store),
    .stat          (stat),
    .busy          (emit_busy),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .failsafe      (failsafe),
    .link_lost     (link_lost),
    .last_channel  (m_tlast)
  );

  // pack result fields from the lowest bit up
  assign m_tdata = {7'b0, link_lost, failsafe, channel_value, channel_index};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for rc_serial_frame_decoder_core
// ----------------------------------------------------------------------------
// Feeds a byte stream of start/data/flag/end frames, bad end bytes and line
// noise into the slave side. Every accepted byte runs through a frame
// decoder model kept here, which queues the 16 channel results that a good
// frame gives. Each channel request taken on the master side is checked
// against the oldest queued result. Both sides idle at random in the first
// two phases and not at all in the third, and the output side holds off for
// a long stretch once so that the decoder backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import rsfd_pkg::*;

  localparam int RANDOM_BYTES = 400;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic [CHANNEL_BITS-1:0] value;
    logic                    failsafe;
    logic                    lost;
    logic                    last;
  } chan_result_t;

  typedef struct {
    logic [7:0] data;
    int         phase;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [3:0] channel_index, [14:4] channel_value,
                                  // [15] failsafe, [16] link_lost
  logic        m_tlast;           // last_channel

  rx_item_t     rx_pending[$];
  chan_result_t chan_expected[$];
  int           rx_total    = 0;
  int           rx_accepted = 0;
  int           flow_phase  = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  // decoder model state
  logic [POS_W-1:0]      frm_pos      = HUNT_POS;
  logic [STORE_BITS-1:0] frm_bits     = '0;
  logic                  frm_failsafe = 1'b0;
  logic                  frm_lost     = 1'b0;

  rc_serial_frame_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stream bit b of the data bytes is channel b/11, bit b%11
  function automatic void absorb_rx_byte(logic [7:0] rx);
    chan_result_t res;
    if (frm_pos >= FIRST_POS && frm_pos <= LAST_DATA) begin
      frm_bits[int'(frm_pos - FIRST_POS) * 8 +: 8] |= rx;
      frm_pos = frm_pos + POS_W'(1);
    end else if (frm_pos == FLAG_POS) begin
      frm_failsafe = rx[FAILSAFE_BIT];
      frm_lost     = rx[LOST_BIT];
      frm_pos      = END_POS;
    end else if (frm_pos == END_POS) begin
      frm_pos = HUNT_POS;
      if (rx == END_CODE) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          res.idx      = IDX_W'(k);
          res.value    = frm_bits[k * CHANNEL_BITS +: CHANNEL_BITS];
          res.failsafe = frm_failsafe;
          res.lost     = frm_lost;
          res.last     = (k == NUM_CHANNELS - 1);
          chan_expected.push_back(res);
        end
      end
    end else begin
      // hunting: every byte wipes the store
      frm_bits = '0;
      frm_pos  = (rx == START_CODE) ? FIRST_POS : HUNT_POS;
    end
  endfunction

  function automatic void queue_byte(logic [7:0] data, int phase);
    rx_item_t item;
    item.data  = data;
    item.phase = phase;
    rx_pending.push_back(item);
    rx_total++;
  endfunction

  function automatic int send_idle_pct(int phase);
    return (phase == 0) ? 11 : (phase == 1) ? 84 : 0;
  endfunction

  function automatic int take_idle_pct(int phase);
    return (phase == 0) ? 84 : (phase == 1) ? 11 : 0;
  endfunction

  // driver
  always @(posedge clk) begin
    rx_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_rx_byte(s_tdata);
        rx_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_pending.size() != 0 &&
            $urandom_range(99) >= send_idle_pct(rx_pending[0].phase)) begin
          nxt = rx_pending.pop_front();
          s_tvalid   <= 1'b1;
          s_tdata    <= nxt.data;
          flow_phase <= nxt.phase;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and output-side flow control
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    chan_result_t got;
    chan_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.idx      = m_tdata[3:0];
        got.value    = m_tdata[14:4];
        got.failsafe = m_tdata[15];
        got.lost     = m_tdata[16];
        got.last     = m_tlast;
        if (chan_expected.size() == 0) begin
          $display("%0t: unexpected channel request: ch %0d val %0d fs %0b lost %0b last %0b",
                   $time, got.idx, got.value, got.failsafe, got.lost, got.last);
          error_count++;
        end else begin
          want = chan_expected.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected ch %0d val %0d fs %0b lost %0b last %0b",
                     $time, want.idx, want.value, want.failsafe, want.lost, want.last);
            $display("%0t:          actual   ch %0d val %0d fs %0b lost %0b last %0b",
                     $time, got.idx, got.value, got.failsafe, got.lost, got.last);
            error_count++;
          end
        end
      end
      // long back-pressure once the no-idle phase starts
      if (flow_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= take_idle_pct(flow_phase));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int         counted;
    int         phase;
    int         kind;
    int         fill;
    int         n_noise;
    logic [7:0] data;

    // directed: noise, then a frame with channels 0..7 at zero and
    // channels 8..15 at full scale, all flag bits set, good end byte
    queue_byte(8'hFF, 0);
    queue_byte(START_CODE, 0);
    for (int i = 0; i < DATA_BYTES; i++)
      queue_byte((i < DATA_BYTES / 2) ? 8'h00 : 8'hFF, 0);
    queue_byte(8'hFF, 0);
    queue_byte(END_CODE, 0);

    // random: mostly well-formed frames, some bad end bytes and noise
    counted = 0;
    while (counted < RANDOM_BYTES) begin
      phase = (counted * 3) / RANDOM_BYTES;
      kind  = $urandom_range(99);
      if (kind < 85) begin
        fill = $urandom_range(9);
        queue_byte(START_CODE, phase);
        for (int i = 0; i < DATA_BYTES; i++) begin
          data = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(255));
          queue_byte(data, phase);
        end
        queue_byte(8'($urandom_range(255)), phase);
        if (kind < 70)
          queue_byte(END_CODE, phase);
        else
          queue_byte(8'($urandom_range(255, 1)), phase);
        counted += DATA_BYTES + 3;
      end else begin
        n_noise = $urandom_range(4, 1);
        repeat (n_noise)
          queue_byte(8'($urandom_range(255)), phase);
        counted += n_noise;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (rx_accepted < rx_total) @(posedge clk);
    while (chan_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
